@@ rtl/ws2812_spi_frame_encoder_unit_assert.svh @@
// ----------------------------------------------------------------------------
// WS2812 SPI frame encoder assertion macros
// Shared property macros used by the port checker.
// ----------------------------------------------------------------------------
`ifndef WS2812_SPI_FRAME_ENCODER_UNIT_ASSERT_SVH
`define WS2812_SPI_FRAME_ENCODER_UNIT_ASSERT_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define WSFE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsfe assertion failed");

// Checks that cons holds in the cycle after ante holds.
`define WSFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsfe assertion failed");

`endif

@@ rtl/wsfe_pkg.sv @@
// ----------------------------------------------------------------------------
// WS2812 SPI frame encoder package
// Request and result types, control structs, gamma table and bit expansion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsfe_pkg;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_PULL  = 1'b1;

  localparam logic [2:0] CODE_ONE  = 3'h6;
  localparam logic [2:0] CODE_ZERO = 3'h4;

  localparam logic [1:0] CH_GREEN = 2'd0;
  localparam logic [1:0] CH_RED   = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [1:0] PART_HIGH = 2'd0;
  localparam logic [1:0] PART_MID  = 2'd1;
  localparam logic [1:0] PART_LOW  = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_req_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       frame_last;
  } out_res_t;

  typedef struct packed {
    logic capture;
    logic do_write;
    logic do_read;
    logic do_emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  localparam logic [7:0] GAMMA_LUT [256] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
    8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
    8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
    8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
    8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
    8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
    8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
    8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
    8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,
    8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
    8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,
    8'd37,  8'd38,  8'd39,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
    8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd50,
    8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
    8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,
    8'd69,  8'd70,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,
    8'd79,  8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,
    8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,  8'd99,  8'd101,
    8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
    8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
    8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
    8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
    8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
    8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
    8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
    8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
    8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
  };

  function automatic logic [23:0] expand_bits(input logic [7:0] c);
    logic [23:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      w[3*i +: 3] = c[i] ? CODE_ONE : CODE_ZERO;
    end
    return w;
  endfunction

endpackage

@@ rtl/ws2812_spi_frame_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// WS2812 SPI frame encoder
// Stores gamma-corrected LED colors and returns the encoded SPI frame bytewise.
// ----------------------------------------------------------------------------
// A write request carries an LED index and raw red, green and blue bytes; each
// byte passes the gamma table and the result is stored for that LED. Indexes
// at or above NUM_LEDS are dropped. A pull request returns the next byte of
// the frame: RESET_LEAD_BYTES zero bytes, then green, red and blue for every
// LED, each color bit sent as three line bits. frame_last marks the final
// byte, after which the frame starts over.
// A write passes the request register and then the color memory write. A pull
// passes the request register, the registered color memory read and the result
// register, entering the result register once the output is free. No new
// request is taken until the current one is done. Writes produce no result.
// Reset clears the written flags and returns to the start of the frame; the
// color memory itself is not cleared, since unwritten LEDs send zero bytes.
// While the receiver stalls, the result holds, further writes may be accepted,
// and a pull then waits in its last step until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ws2812_spi_frame_encoder_unit #(
  parameter int NUM_LEDS         = 64,
  parameter int RESET_LEAD_BYTES = 21
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wsfe_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output wsfe_pkg::out_res_t out_res
);

  wsfe_pkg::cmd_t    cmd;
  wsfe_pkg::status_t status;

  wsfe_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req.req_type),
    .in_stall    (in_stall),
    .status      (status),
    .cmd         (cmd)
  );

  wsfe_dpath #(
    .NUM_LEDS         (NUM_LEDS),
    .RESET_LEAD_BYTES (RESET_LEAD_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_stall (out_stall)
  );

endmodule

@@ rtl/wsfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// WS2812 SPI frame encoder controller
// Sequences request capture, color store writes, store reads and result emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsfe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_req_type,
  output logic             in_stall,
  input  wsfe_pkg::status_t status,
  output wsfe_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WRITE = 4'b0010,
    S_READ  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = (in_req_type == wsfe_pkg::REQ_PULL) ? S_READ : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.do_write = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_READ: begin
        cmd.do_read = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.do_emit = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/wsfe_dpath.sv @@
// ----------------------------------------------------------------------------
// WS2812 SPI frame encoder datapath
// Request register, color memory, written flags, frame position and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsfe_dpath #(
  parameter int NUM_LEDS         = 64,
  parameter int RESET_LEAD_BYTES = 21
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wsfe_pkg::in_req_t  in_req,
  input  wsfe_pkg::cmd_t     cmd,
  output wsfe_pkg::status_t  status,
  output logic               out_valid,
  output wsfe_pkg::out_res_t out_res,
  input  logic               out_stall
);

  localparam int AW  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int LCW = $clog2(RESET_LEAD_BYTES + 1);
  localparam logic [AW-1:0]  LED_LAST  = AW'(NUM_LEDS - 1);
  localparam logic [LCW-1:0] LEAD_LAST = LCW'(RESET_LEAD_BYTES - 1);
  localparam logic [7:0]     IDX_BOUND = 8'(NUM_LEDS);

  wsfe_pkg::in_req_t req_r;

  logic [23:0]         mem [NUM_LEDS];
  logic [NUM_LEDS-1:0] written_r;
  logic [23:0]         rd_data_r;
  logic                rd_hit_r;

  logic           lead_r;
  logic [LCW-1:0] lead_cnt_r;
  logic [AW-1:0]  led_r;
  logic [1:0]     chan_r;
  logic [1:0]     part_r;

  logic           lead_nxt;
  logic [LCW-1:0] lead_cnt_nxt;
  logic [AW-1:0]  led_nxt;
  logic [1:0]     chan_nxt;
  logic [1:0]     part_nxt;

  logic               out_valid_r;
  wsfe_pkg::out_res_t out_res_r;

  logic          idx_ok;
  logic [AW-1:0] waddr;
  logic [23:0]   wdata;
  logic [7:0]    color;
  logic [23:0]   wave;
  logic [7:0]    wave_byte;
  logic          is_last;

  assign idx_ok = req_r.led_index < IDX_BOUND;
  assign waddr  = req_r.led_index[AW-1:0];
  assign wdata  = {wsfe_pkg::GAMMA_LUT[req_r.green],
                   wsfe_pkg::GAMMA_LUT[req_r.red],
                   wsfe_pkg::GAMMA_LUT[req_r.blue]};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_write && idx_ok) begin
      mem[waddr] <= wdata;
    end
    if (cmd.do_read) begin
      rd_data_r <= mem[led_r];
      rd_hit_r  <= written_r[led_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (cmd.do_write && idx_ok) begin
      written_r[waddr] <= 1'b1;
    end
  end

  always_comb begin
    unique case (chan_r)
      wsfe_pkg::CH_GREEN: color = rd_data_r[23:16];
      wsfe_pkg::CH_RED:   color = rd_data_r[15:8];
      wsfe_pkg::CH_BLUE:  color = rd_data_r[7:0];
      default:            color = 8'h00;
    endcase
    wave = wsfe_pkg::expand_bits(color);
    unique case (part_r)
      wsfe_pkg::PART_HIGH: wave_byte = wave[23:16];
      wsfe_pkg::PART_MID:  wave_byte = wave[15:8];
      wsfe_pkg::PART_LOW:  wave_byte = wave[7:0];
      default:             wave_byte = 8'h00;
    endcase
  end

  assign is_last = !lead_r && (led_r == LED_LAST) && (chan_r == wsfe_pkg::CH_BLUE) &&
                   (part_r == wsfe_pkg::PART_LOW);

  always_comb begin
    lead_nxt     = lead_r;
    lead_cnt_nxt = lead_cnt_r;
    led_nxt      = led_r;
    chan_nxt     = chan_r;
    part_nxt     = part_r;
    if (lead_r) begin
      if (lead_cnt_r == LEAD_LAST) begin
        lead_nxt = 1'b0;
        led_nxt  = '0;
        chan_nxt = wsfe_pkg::CH_GREEN;
        part_nxt = wsfe_pkg::PART_HIGH;
      end else begin
        lead_cnt_nxt = lead_cnt_r + 1'b1;
      end
    end else if (part_r != wsfe_pkg::PART_LOW) begin
      part_nxt = part_r + 2'd1;
    end else begin
      part_nxt = wsfe_pkg::PART_HIGH;
      if (chan_r != wsfe_pkg::CH_BLUE) begin
        chan_nxt = chan_r + 2'd1;
      end else begin
        chan_nxt = wsfe_pkg::CH_GREEN;
        if (led_r == LED_LAST) begin
          lead_nxt     = 1'b1;
          lead_cnt_nxt = '0;
        end else begin
          led_nxt = led_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r     <= 1'b1;
      lead_cnt_r <= '0;
      led_r      <= '0;
      chan_r     <= wsfe_pkg::CH_GREEN;
      part_r     <= wsfe_pkg::PART_HIGH;
    end else if (cmd.do_emit) begin
      lead_r     <= lead_nxt;
      lead_cnt_r <= lead_cnt_nxt;
      led_r      <= led_nxt;
      chan_r     <= chan_nxt;
      part_r     <= part_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.do_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_emit) begin
      out_res_r.spi_byte   <= (lead_r || !rd_hit_r) ? 8'h00 : wave_byte;
      out_res_r.frame_last <= is_last;
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_res         = out_res_r;

endmodule

@@ rtl/wsfe_checker.sv @@
// ----------------------------------------------------------------------------
// WS2812 SPI frame encoder port checker
// Port-level timing checks on request and result channels, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ws2812_spi_frame_encoder_unit_assert.svh"

module wsfe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input wsfe_pkg::in_req_t  in_req,
  input logic               out_valid,
  input logic               out_stall,
  input wsfe_pkg::out_res_t out_res
);

  logic in_acc;
  logic pull_acc;
  logic write_acc;

  assign in_acc    = in_valid && !in_stall;
  assign pull_acc  = in_acc && (in_req.req_type == wsfe_pkg::REQ_PULL);
  assign write_acc = in_acc && (in_req.req_type == wsfe_pkg::REQ_WRITE);

  `WSFE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_res))
  `WSFE_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall)
  `WSFE_ASSERT_NOW(a_pull_result, pull_acc && !out_valid, ##3 out_valid)
  `WSFE_ASSERT_NOW(a_write_silent, write_acc && !out_valid, ##3 !out_valid)

endmodule

bind ws2812_spi_frame_encoder_unit wsfe_checker u_wsfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_res   (out_res)
);
